// File: rtl/core/io_wd_pkg.sv
// ----------------------------------------------------------------------------
// io_wd_pkg
// Shared types, register indexes and the fixed window table of the
// I/O window decoder.
// ----------------------------------------------------------------------------
package io_wd_pkg;

    localparam int unsigned NUM_LANES = 4;

    // register indexes on the configuration port (paddr[3:2])
    localparam logic [1:0] REG_ALIAS_MASK     = 2'd0;
    localparam logic [1:0] REG_UNMAPPED_VALUE = 2'd1;
    localparam logic [1:0] REG_DEVICE_PRESENT = 2'd2;

    localparam logic [31:0] ALIAS_MASK_RST     = 32'h0001_FFFF;
    localparam logic [7:0]  UNMAPPED_VALUE_RST = 8'h00;
    localparam logic [5:0]  DEVICE_PRESENT_RST = 6'h3F;

    // access sizes
    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_LONG = 2'd2;

    // result status codes
    localparam logic [1:0] ST_ROUTED    = 2'd0;
    localparam logic [1:0] ST_UNPOP     = 2'd1;
    localparam logic [1:0] ST_NO_WINDOW = 2'd2;

    // device codes
    localparam logic [2:0] DEV_VIA1   = 3'd0;
    localparam logic [2:0] DEV_VIA2   = 3'd1;
    localparam logic [2:0] DEV_SCC    = 3'd2;
    localparam logic [2:0] DEV_SCSI   = 3'd3;
    localparam logic [2:0] DEV_ASC    = 3'd4;
    localparam logic [2:0] DEV_FLOPPY = 3'd5;

    localparam logic [12:0] SCSI_WRITE_REG = 13'h0201;
    localparam logic [4:0]  WAIT_ESYNC     = 5'd16;
    localparam logic [4:0]  WAIT_IO        = 5'd2;

    typedef enum logic [1:0] {
        XF_PLAIN  = 2'd0,
        XF_MASKA0 = 2'd1,
        XF_FIXED  = 2'd2,
        XF_STRIDE = 2'd3
    } t_xform;

    typedef struct packed {
        logic [2:0] dev;
        logic [4:0] wait_cycles;
        logic       esync;
        t_xform     xform;
    } t_win;

    typedef struct packed {
        logic [31:0] alias_mask;
        logic [7:0]  unmapped_value;
        logic [5:0]  device_present;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  device;
        logic [12:0] sub_offset;
        logic        wr_access;
        logic [7:0]  byte_value;
        logic [4:0]  wait_cycles;
        logic        e_sync;
        logic [2:0]  lane_pad;
        logic [1:0]  lane;
        logic        last;
    } t_res;

    // windows are 8 KiB aligned below 0x18000; index is {off[16], off[14:13]}
    function automatic t_win win_lookup(input logic [2:0] idx);
        t_win w;
        unique case (idx)
            3'd0:    w = '{DEV_VIA1,   WAIT_ESYNC, 1'b1, XF_MASKA0};
            3'd1:    w = '{DEV_VIA2,   WAIT_ESYNC, 1'b1, XF_MASKA0};
            3'd2:    w = '{DEV_SCC,    WAIT_IO,    1'b0, XF_PLAIN};
            3'd3:    w = '{DEV_SCSI,   WAIT_IO,    1'b0, XF_FIXED};
            3'd4:    w = '{DEV_SCSI,   WAIT_IO,    1'b0, XF_PLAIN};
            3'd5:    w = '{DEV_SCSI,   WAIT_IO,    1'b0, XF_FIXED};
            3'd6:    w = '{DEV_ASC,    WAIT_IO,    1'b0, XF_PLAIN};
            default: w = '{DEV_FLOPPY, WAIT_IO,    1'b0, XF_STRIDE};
        endcase
        return w;
    endfunction

endpackage

// File: rtl/core/io_wd_if.sv
// ----------------------------------------------------------------------------
// io_wd_req_if / io_wd_res_if
// Valid/ready channels for bus access requests and byte results.
// ----------------------------------------------------------------------------
interface io_wd_req_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [31:0] address;
    logic [1:0]  access_size;
    logic [31:0] write_data;

    modport source (output valid, func, address, access_size, write_data, input ready);
    modport sink   (input valid, func, address, access_size, write_data, output ready);
endinterface

interface io_wd_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [2:0]  device;
    logic [12:0] sub_offset;
    logic        wr_access;
    logic [7:0]  byte_value;
    logic [4:0]  wait_cycles;
    logic        e_sync;
    logic [1:0]  lane;
    logic        last;

    modport source (output valid, status, device, sub_offset, wr_access, byte_value,
                    wait_cycles, e_sync, lane, last, input ready);
    modport sink   (input valid, status, device, sub_offset, wr_access, byte_value,
                    wait_cycles, e_sync, lane, last, output ready);
endinterface

// File: rtl/core/io_window_decoder.sv
// ----------------------------------------------------------------------------
// io_window_decoder
// A request passes the input request register, then the merge result buffer.
// Throughput: one result per cycle while o_res.ready is high; an access
// issues 1, 2 or 4 results (byte, halfword, longword) through the single
// result issue port. Four decode lanes run in parallel, so a following
// access waits only on the issue of the current one.
// Reset: synchronous active low; only control and config registers reset.
// ----------------------------------------------------------------------------
module io_window_decoder (
    input  logic              i_clk,
    input  logic              i_rst_n,
    io_wd_req_if.sink         i_req,
    io_wd_res_if.source       o_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import io_wd_pkg::*;

    t_cfg        r_cfg;
    logic        r_in_valid;
    logic        r_func;
    logic [31:0] r_address;
    logic [1:0]  r_access_size;
    logic [31:0] r_write_data;
    t_res        lane_res [NUM_LANES];
    t_res        res;
    logic        free;
    logic        load;
    logic        accept;
    logic        cfg_wr;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.alias_mask     <= ALIAS_MASK_RST;
            r_cfg.unmapped_value <= UNMAPPED_VALUE_RST;
            r_cfg.device_present <= DEVICE_PRESENT_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_ALIAS_MASK:     r_cfg.alias_mask     <= pwdata;
                REG_UNMAPPED_VALUE: r_cfg.unmapped_value <= pwdata[7:0];
                REG_DEVICE_PRESENT: r_cfg.device_present <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_ALIAS_MASK:     prdata = r_cfg.alias_mask;
            REG_UNMAPPED_VALUE: prdata = {24'd0, r_cfg.unmapped_value};
            REG_DEVICE_PRESENT: prdata = {26'd0, r_cfg.device_present};
            default:            prdata = 32'd0;
        endcase
    end

    // input request register
    assign i_req.ready = !r_in_valid || free;
    assign accept      = i_req.valid && i_req.ready;
    assign load        = r_in_valid && free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (load) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func        <= i_req.func;
            r_address     <= i_req.address;
            r_access_size <= i_req.access_size;
            r_write_data  <= i_req.write_data;
        end
    end

    // decode lanes, one per byte of a longword
    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        io_wd_lane u_lane (
            .i_lane        (2'(g)),
            .i_func        (r_func),
            .i_address     (r_address),
            .i_access_size (r_access_size),
            .i_write_data  (r_write_data),
            .i_cfg         (r_cfg),
            .o_res         (lane_res[g])
        );
    end

    // merge and issue
    io_wd_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_lanes (lane_res),
        .o_free  (free),
        .o_valid (o_res.valid),
        .i_ready (o_res.ready),
        .o_res   (res)
    );

    assign o_res.status      = res.status;
    assign o_res.device      = res.device;
    assign o_res.sub_offset  = res.sub_offset;
    assign o_res.wr_access   = res.wr_access;
    assign o_res.byte_value  = res.byte_value;
    assign o_res.wait_cycles = res.wait_cycles;
    assign o_res.e_sync      = res.e_sync;
    assign o_res.lane        = res.lane;
    assign o_res.last        = res.last;

endmodule

// File: rtl/core/io_wd_lane.sv
// ----------------------------------------------------------------------------
// io_wd_lane
// Decodes one byte of an access: address offset, alias mask, window
// match and sub-register transform.
// ----------------------------------------------------------------------------
module io_wd_lane (
    input  logic                [1:0]  i_lane,
    input  logic                       i_func,
    input  logic                [31:0] i_address,
    input  logic                [1:0]  i_access_size,
    input  logic                [31:0] i_write_data,
    input  io_wd_pkg::t_cfg            i_cfg,
    output io_wd_pkg::t_res            o_res
);
    import io_wd_pkg::*;

    logic [31:0] byte_addr;
    logic [31:0] off;
    logic        hit;
    t_win        win;
    logic        present;
    logic [7:0]  data_byte;
    logic [12:0] rel;
    logic [12:0] sub;

    // byte address and alias mask, wrapping past the top
    assign byte_addr = i_address + {30'd0, i_lane};
    assign off       = byte_addr & i_cfg.alias_mask;

    // windows cover 0x00000-0x07fff and 0x10000-0x17fff
    assign hit     = (off[31:17] == 15'd0) && !off[15];
    assign win     = win_lookup({off[16], off[14:13]});
    assign present = i_cfg.device_present[win.dev];
    assign rel     = off[12:0];

    // big-endian byte pick from right-aligned write data
    always_comb begin
        case (i_access_size)
            SIZE_BYTE: data_byte = i_write_data[7:0];
            SIZE_HALF: data_byte = i_lane[0] ? i_write_data[7:0] : i_write_data[15:8];
            default: begin
                case (i_lane)
                    2'd0:    data_byte = i_write_data[31:24];
                    2'd1:    data_byte = i_write_data[23:16];
                    2'd2:    data_byte = i_write_data[15:8];
                    default: data_byte = i_write_data[7:0];
                endcase
            end
        endcase
    end

    // sub-register transform
    always_comb begin
        case (win.xform)
            XF_MASKA0: sub = {rel[12:1], 1'b0};
            XF_FIXED:  sub = i_func ? SCSI_WRITE_REG : 13'd0;
            XF_STRIDE: sub = {9'd0, rel[12:9]};
            default:   sub = rel;
        endcase
    end

    // assemble the result
    always_comb begin
        o_res           = '0;
        o_res.wr_access = i_func;
        o_res.lane      = i_lane;
        case (i_access_size)
            SIZE_BYTE: o_res.last = (i_lane == 2'd0);
            SIZE_HALF: o_res.last = (i_lane == 2'd1);
            default:   o_res.last = (i_lane == 2'd3);
        endcase
        if (!hit) begin
            o_res.status     = ST_NO_WINDOW;
            o_res.byte_value = i_func ? data_byte : i_cfg.unmapped_value;
        end else begin
            o_res.status      = present ? ST_ROUTED : ST_UNPOP;
            o_res.device      = win.dev;
            o_res.sub_offset  = sub;
            o_res.wait_cycles = win.esync ? 5'd0 : win.wait_cycles;
            o_res.e_sync      = win.esync;
            if (i_func) begin
                o_res.byte_value = data_byte;
            end else begin
                o_res.byte_value = present ? 8'd0 : i_cfg.unmapped_value;
            end
        end
    end

endmodule

// File: rtl/core/io_wd_merge.sv
// ----------------------------------------------------------------------------
// io_wd_merge
// Holds the lane results of one access and issues them one per cycle while
// i_ready is high, lane 0 first, up to the lane marked last.
// ----------------------------------------------------------------------------
module io_wd_merge (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  io_wd_pkg::t_res       i_lanes [io_wd_pkg::NUM_LANES],
    output logic                  o_free,
    output logic                  o_valid,
    input  logic                  i_ready,
    output io_wd_pkg::t_res       o_res
);
    import io_wd_pkg::*;

    t_res       r_buf [NUM_LANES];
    logic       r_valid;
    logic [1:0] r_idx;
    logic       fire;

    assign o_res   = r_buf[r_idx];
    assign o_valid = r_valid;
    assign fire    = r_valid && i_ready;
    assign o_free  = !r_valid || (fire && o_res.last);

    // result buffer, loaded whole from the lanes
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_buf <= i_lanes;
        end
    end

    // issue pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= 2'd0;
        end else if (fire && o_res.last) begin
            r_valid <= 1'b0;
        end else if (fire) begin
            r_idx <= r_idx + 2'd1;
        end
    end

endmodule

// File: test/io_wd_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// io_wd_checker
// Watches the request, result and configuration channels of the I/O window
// decoder, keeps its own copy of the decode registers, predicts the byte
// results of every accepted request and compares them in order.
// ----------------------------------------------------------------------------
module io_wd_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    io_wd_req_if        i_req,
    io_wd_res_if        i_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          o_fail_count,
    output int          o_pending
);
    import io_wd_pkg::*;

    typedef struct packed {
        logic [31:0] lo;
        logic [31:0] hi;
        logic [2:0]  dev;
        logic        esync;
        t_xform      xf;
    } t_io_window;

    // shadow of the decode registers
    logic [31:0] cfg_mask;
    logic [7:0]  cfg_unmapped;
    logic [5:0]  cfg_present;

    t_res expected_bytes[$];
    int   mismatches = 0;

    assign o_fail_count = mismatches;

    // decode windows in priority order, half open [lo, hi)
    function automatic t_io_window window_at(int unsigned k);
        case (k)
            0:       return '{32'h0_0000, 32'h0_2000, DEV_VIA1,   1'b1, XF_MASKA0};
            1:       return '{32'h0_2000, 32'h0_4000, DEV_VIA2,   1'b1, XF_MASKA0};
            2:       return '{32'h0_4000, 32'h0_6000, DEV_SCC,    1'b0, XF_PLAIN};
            3:       return '{32'h0_6000, 32'h0_8000, DEV_SCSI,   1'b0, XF_FIXED};
            4:       return '{32'h1_0000, 32'h1_2000, DEV_SCSI,   1'b0, XF_PLAIN};
            5:       return '{32'h1_2000, 32'h1_4000, DEV_SCSI,   1'b0, XF_FIXED};
            6:       return '{32'h1_4000, 32'h1_6000, DEV_ASC,    1'b0, XF_PLAIN};
            default: return '{32'h1_6000, 32'h1_8000, DEV_FLOPPY, 1'b0, XF_STRIDE};
        endcase
    endfunction

    // route one byte of an access
    function automatic t_res route_byte(logic [31:0] baddr, logic wr, logic [7:0] wbyte);
        t_res        r;
        t_io_window  w;
        logic [31:0] off;
        logic [31:0] rel;
        bit          hit;
        bit          present;
        r   = '0;
        off = baddr & cfg_mask;
        hit = 1'b0;
        w   = window_at(0);
        for (int k = 0; k < 8 && !hit; k++) begin
            w = window_at(k);
            if (off >= w.lo && off < w.hi)
                hit = 1'b1;
        end
        r.wr_access = wr;
        if (!hit) begin
            // nothing decoded: unmapped read, write dropped
            r.status     = ST_NO_WINDOW;
            r.byte_value = wr ? wbyte : cfg_unmapped;
            return r;
        end
        present  = cfg_present[w.dev];
        r.status = present ? ST_ROUTED : ST_UNPOP;
        r.device = w.dev;
        rel      = off - w.lo;
        case (w.xf)
            XF_MASKA0: rel = rel & ~32'd1;
            XF_FIXED:  rel = wr ? 32'(SCSI_WRITE_REG) : 32'd0;
            XF_STRIDE: rel = (rel >> 9) & 32'h0F;
            default:   rel = rel;
        endcase
        r.sub_offset  = rel[12:0];
        r.byte_value  = wr ? wbyte : (present ? 8'h00 : cfg_unmapped);
        r.wait_cycles = w.esync ? 5'd0 : WAIT_IO;
        r.e_sync      = w.esync;
        return r;
    endfunction

    // split an access big-endian into byte results
    function automatic void decode_access(logic wr, logic [31:0] addr, logic [1:0] size,
                                          logic [31:0] data);
        int   n;
        t_res r;
        n = (size == SIZE_BYTE) ? 1 : (size == SIZE_HALF) ? 2 : 4;
        for (int k = 0; k < n; k++) begin
            r = route_byte(addr + 32'(k), wr, 8'(data >> (8 * (n - 1 - k))));
            r.lane = 2'(k);
            r.last = (k == n - 1);
            expected_bytes.push_back(r);
        end
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            cfg_mask     = ALIAS_MASK_RST;
            cfg_unmapped = UNMAPPED_VALUE_RST;
            cfg_present  = DEVICE_PRESENT_RST;
            expected_bytes.delete();
        end else begin
            // register writes
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_ALIAS_MASK:     cfg_mask     = pwdata;
                    REG_UNMAPPED_VALUE: cfg_unmapped = pwdata[7:0];
                    REG_DEVICE_PRESENT: cfg_present  = pwdata[5:0];
                    default: ;
                endcase
            end
            // compare results before queuing new requests
            if (i_res.valid && i_res.ready) begin
                if (expected_bytes.size() == 0) begin
                    $error("byte result with no request pending: status %0h offset %0h",
                           i_res.status, i_res.sub_offset);
                    mismatches++;
                end else begin
                    want = expected_bytes.pop_front();
                    check_field("status",      32'(want.status),      32'(i_res.status));
                    check_field("device",      32'(want.device),      32'(i_res.device));
                    check_field("sub_offset",  32'(want.sub_offset),  32'(i_res.sub_offset));
                    check_field("wr_access",   32'(want.wr_access),   32'(i_res.wr_access));
                    check_field("byte_value",  32'(want.byte_value),  32'(i_res.byte_value));
                    check_field("wait_cycles", 32'(want.wait_cycles), 32'(i_res.wait_cycles));
                    check_field("e_sync",      32'(want.e_sync),      32'(i_res.e_sync));
                    check_field("lane",        32'(want.lane),        32'(i_res.lane));
                    check_field("last",        32'(want.last),        32'(i_res.last));
                end
            end
            if (i_req.valid && i_req.ready)
                decode_access(i_req.func, i_req.address, i_req.access_size, i_req.write_data);
        end
        o_pending <= expected_bytes.size();
    end

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives bus access requests and register writes into the I/O window
// decoder under several decode settings and flow-control patterns; the
// checker beside the block predicts and compares every byte result.
// ----------------------------------------------------------------------------
module testbench;
    import io_wd_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;

    // illegal size code, decoded as a longword
    localparam logic [1:0] SIZE_THREE = 2'd3;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          failures;
    int          pending;
    int          idle_mode;
    int          quiet_cycles = 0;
    logic [31:0] cur_mask;

    io_wd_req_if req_ch ();
    io_wd_res_if res_ch ();

    io_window_decoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    io_wd_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_res        (res_ch),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .o_fail_count (failures),
        .o_pending    (pending)
    );

    // 4 ns clock
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // result side back-pressure
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (idle_mode == 2)
                res_ch.ready <= ($urandom_range(0, 99) >= 58);
            else if (idle_mode == 3)
                res_ch.ready <= ($urandom_range(0, 99) >= 37);
            else
                res_ch.ready <= 1'b1;
        end
    end

    // stop when nothing moves for too long
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic bit sender_idles();
        if (idle_mode == 1)
            return $urandom_range(0, 99) < 58;
        if (idle_mode == 3)
            return $urandom_range(0, 99) < 37;
        return 1'b0;
    endfunction

    function automatic logic [31:0] window_base(int unsigned k);
        case (k)
            0:       return 32'h0_0000;
            1:       return 32'h0_2000;
            2:       return 32'h0_4000;
            3:       return 32'h0_6000;
            4:       return 32'h1_0000;
            5:       return 32'h1_2000;
            6:       return 32'h1_4000;
            default: return 32'h1_6000;
        endcase
    endfunction

    // mostly decodable addresses, aliased through the bits the mask drops
    function automatic logic [31:0] pick_address();
        logic [31:0]  a;
        int unsigned  kind;
        kind = $urandom_range(0, 9);
        if (kind <= 5)
            a = window_base($urandom_range(0, 7)) + $urandom_range(0, 32'h1FFF);
        else if (kind <= 7)
            a = window_base($urandom_range(0, 7)) + 32'h2000 - $urandom_range(1, 4);
        else if (kind == 8)
            a = ($urandom_range(0, 1) ? 32'h0_8000 : 32'h1_8000) + $urandom_range(0, 32'h7FFF);
        else
            return $urandom;
        return a | ($urandom & ~cur_mask);
    endfunction

    task automatic send_access(logic wr, logic [31:0] addr, logic [1:0] size,
                               logic [31:0] data);
        while (sender_idles()) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.func        <= wr;
        req_ch.address     <= addr;
        req_ch.access_size <= size;
        req_ch.write_data  <= data;
        @(posedge i_clk);
        while (!req_ch.ready)
            @(posedge i_clk);
    endtask

    // hold requests until every byte result is back
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_decode(logic [31:0] mask, logic [31:0] unmapped, logic [31:0] present);
        wait_drained();
        cur_mask = mask;
        cfg_write(REG_ALIAS_MASK, mask);
        cfg_write(REG_UNMAPPED_VALUE, unmapped);
        cfg_write(REG_DEVICE_PRESENT, present);
    endtask

    task automatic run_random(int count, int mode, int hold_at);
        idle_mode = mode;
        for (int i = 0; i < count; i++) begin
            if (hold_at != 0 && i == hold_at)
                wait_drained();
            send_access(1'($urandom), pick_address(), 2'($urandom_range(0, 3)), $urandom);
        end
    endtask

    initial begin
        i_rst_n             = 1'b0;
        idle_mode           = 0;
        cur_mask            = ALIAS_MASK_RST;
        req_ch.valid        = 1'b0;
        req_ch.func         = 1'b0;
        req_ch.address      = '0;
        req_ch.access_size  = SIZE_BYTE;
        req_ch.write_data   = '0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: window edges, straddles, holes, wrap and size three
        send_access(1'b0, 32'h0000_0000, SIZE_BYTE,  32'h0000_0000);
        send_access(1'b1, 32'h0000_0001, SIZE_BYTE,  32'h0000_00FF);
        send_access(1'b0, 32'h0000_1FFE, SIZE_LONG,  32'h0000_0000);
        send_access(1'b1, 32'h0000_3FFE, SIZE_LONG,  32'h1234_5678);
        send_access(1'b0, 32'h0000_5FFF, SIZE_HALF,  32'h0000_0000);
        send_access(1'b1, 32'h0000_6000, SIZE_LONG,  32'hA5A5_A5A5);
        send_access(1'b0, 32'h0000_7FFF, SIZE_BYTE,  32'h0000_0000);
        send_access(1'b0, 32'h0000_7FFE, SIZE_LONG,  32'h0000_0000);
        send_access(1'b1, 32'h0000_C000, SIZE_HALF,  32'h0000_BEEF);
        send_access(1'b0, 32'h0000_FFFE, SIZE_LONG,  32'h0000_0000);
        send_access(1'b1, 32'h0001_1FFF, SIZE_BYTE,  32'h0000_0042);
        send_access(1'b1, 32'h0001_3FFE, SIZE_LONG,  32'h0102_0304);
        send_access(1'b0, 32'h0001_5FFF, SIZE_HALF,  32'h0000_0000);
        send_access(1'b0, 32'h0001_7FFE, SIZE_LONG,  32'h0000_0000);
        send_access(1'b1, 32'h0001_7E00, SIZE_BYTE,  32'h0000_0011);
        send_access(1'b0, 32'h0001_FFFF, SIZE_BYTE,  32'h0000_0000);
        send_access(1'b1, 32'h0000_4100, SIZE_THREE, 32'hDEAD_BEEF);
        send_access(1'b0, 32'hFFFF_FFFE, SIZE_LONG,  32'h0000_0000);
        send_access(1'b1, 32'hFFFF_4000, SIZE_LONG,  32'hFFFF_FFFF);
        send_access(1'b0, 32'hFFFF_FFFF, SIZE_THREE, 32'hFFFF_FFFF);
        send_access(1'b1, 32'h0001_0000, SIZE_HALF,  32'h0000_0000);

        // random phases across decode settings and flow-control patterns
        set_decode(32'h0001_FFFF, 32'hFFFF_FFA5, $urandom);
        run_random(40, 1, 0);
        set_decode(32'hFFFF_FFFF, 32'h0000_00FF, 32'h0000_0000);
        run_random(40, 2, 0);
        set_decode(32'h0000_0000, 32'hFFFF_FF00, 32'h0000_003F);
        run_random(20, 3, 0);
        set_decode(($urandom & 32'hFFFE_0000) | 32'h0001_FFFF, $urandom, $urandom);
        run_random(40, 0, 20);
        set_decode(32'h0000_FFFF, $urandom, 32'hFFFF_FFFF);
        run_random(30, 3, 0);
        set_decode(32'h0001_FFFF, $urandom, $urandom);
        run_random(30, 1, 0);

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
